// ===== hw/rtl/mbd_pkg.sv =====
// shared types, codes and reset values for the multi-button debounce block
package mbd_pkg;

  localparam int BUTTON_COUNT = 8;
  localparam int IDX_W = $clog2(BUTTON_COUNT);

  // register indexes of the configuration port
  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_HOLD     = 2'd1;
  localparam logic [1:0] REG_MAP      = 2'd2;

  localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
  localparam logic [15:0] HOLD_RESET     = 16'd500;
  localparam logic [63:0] MAP_RESET      = 64'd0;

  // press state codes
  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_PRESSED = 2'd1;
  localparam logic [1:0] ST_HELD    = 2'd2;

  // action codes
  localparam logic [2:0] ACT_NONE         = 3'd0;
  localparam logic [2:0] ACT_TOGGLE_STRIP = 3'd1;
  localparam logic [2:0] ACT_TOGGLE_RELAY = 3'd2;
  localparam logic [2:0] ACT_START_DIM    = 3'd3;
  localparam logic [2:0] ACT_STOP_DIM     = 3'd4;

  localparam logic [7:0] RELAY_MARK = 8'd255;

  // one button's record as kept in the state memory
  typedef struct packed {
    logic [1:0]  press_state;
    logic [31:0] press_start_time;
    logic        last_raw_level;
    logic [31:0] last_change_time;
    logic        stable_level;
  } button_rec_t;

  localparam button_rec_t REC_RESET = '{
    press_state:      ST_IDLE,
    press_start_time: 32'd0,
    last_raw_level:   1'b0,
    last_change_time: 32'd0,
    stable_level:     1'b0
  };

endpackage

// ===== hw/rtl/mbd_if.sv =====
// sample and result channel interfaces
interface mbd_sample_if;
  logic        valid;
  logic        ready;
  logic [7:0]  button_index;
  logic        pressed_level;
  logic [31:0] time_ms;
  logic        strip_on;

  modport source (output valid, button_index, pressed_level, time_ms, strip_on,
                  input ready);
  modport sink (input valid, button_index, pressed_level, time_ms, strip_on,
                output ready);
endinterface

interface mbd_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] target_strip;
  logic [1:0] button_state;
  logic       any_active;

  modport source (output valid, action, target_strip, button_state, any_active,
                  input ready);
  modport sink (input valid, action, target_strip, button_state, any_active,
                output ready);
endinterface

// ===== hw/rtl/multi_button_debounce_hold.sv =====
// multi-button debounce with press / hold detection, top level
// path: an accepted sample waits in the stage one registers, then the output register
// throughput: one sample per cycle while the output takes results; per-button records
//   sit in an 8-entry memory read at acceptance and written back as the sample leaves
//   stage one, with forwarding
// stalls: the input waits only while stage one holds a sample the output cannot take
// reset: synchronous; clears control, registers to defaults, and per-entry valid
//   bits so every button record reads as idle with zero times
module multi_button_debounce_hold (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  mbd_sample_if.sink  sample,
  mbd_result_if.source result
);
  import mbd_pkg::*;

  // configuration registers
  logic [15:0] settle_ms;
  logic [15:0] long_press_ms;
  logic [63:0] strip_map;

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_ms     <= DEBOUNCE_RESET;
      long_press_ms <= HOLD_RESET;
      strip_map     <= MAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE: settle_ms     <= cfg_data[15:0];
        REG_HOLD:     long_press_ms <= cfg_data[15:0];
        REG_MAP:      strip_map     <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake and stage control
  logic        s1_valid;
  logic        s1_advance;
  logic        accept;

  assign s1_advance   = s1_valid && (!result.valid || result.ready);
  assign sample.ready = !s1_valid || s1_advance;
  assign accept       = sample.valid && sample.ready;

  // stage one sample registers
  logic [7:0]  s1_index;
  logic        s1_raw;
  logic [31:0] s1_now;
  logic        s1_on;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_index <= sample.button_index;
      s1_raw   <= sample.pressed_level;
      s1_now   <= sample.time_ms;
      s1_on    <= sample.strip_on;
    end
  end

  // state memory, registered read at acceptance
  button_rec_t rec_mem [BUTTON_COUNT];
  button_rec_t mem_q;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  button_rec_t       rec_new;

  always_ff @(posedge clk) begin
    if (accept) begin
      mem_q <= rec_mem[sample.button_index[IDX_W-1:0]];
    end
    if (wr_en) begin
      rec_mem[wr_addr] <= rec_new;
    end
  end

  // per-entry valid bits and active flags
  logic [BUTTON_COUNT-1:0] rec_valid;
  logic [BUTTON_COUNT-1:0] active;
  logic [BUTTON_COUNT-1:0] active_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= '0;
      active    <= '0;
    end else if (wr_en) begin
      rec_valid[wr_addr] <= 1'b1;
      active             <= active_next;
    end
  end

  // write-back at the acceptance edge, missed by the memory read, held while
  // the sample waits in stage one
  logic              fwd_valid;
  logic [IDX_W-1:0]  fwd_addr;
  button_rec_t       fwd_rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (accept) begin
      fwd_valid <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      fwd_addr <= wr_addr;
      fwd_rec  <= rec_new;
    end
  end

  // record update for the sample in stage one
  logic [IDX_W-1:0] s1_addr;
  logic             in_range;
  button_rec_t      rec_cur;
  logic [7:0]       strip;
  logic             is_relay;
  logic [31:0]      change_time;
  logic [31:0]      since_change;
  logic [31:0]      since_press;
  logic             stable;
  logic [2:0]       action;

  assign s1_addr  = s1_index[IDX_W-1:0];
  assign in_range = (s1_index < 8'(BUTTON_COUNT));
  assign strip    = strip_map[8*s1_addr +: 8];
  assign is_relay = (strip == RELAY_MARK);

  always_comb begin
    priority if (fwd_valid && fwd_addr == s1_addr) begin
      rec_cur = fwd_rec;
    end else if (rec_valid[s1_addr]) begin
      rec_cur = mem_q;
    end else begin
      rec_cur = REC_RESET;
    end
  end

  // debounce: a level change restarts the timer
  assign change_time  = (s1_raw != rec_cur.last_raw_level) ? s1_now
                                                           : rec_cur.last_change_time;
  assign since_change = s1_now - change_time;
  assign stable       = (since_change > {16'd0, settle_ms}) ? s1_raw
                                                            : rec_cur.stable_level;
  assign since_press  = s1_now - rec_cur.press_start_time;

  // press state machine
  always_comb begin
    rec_new                  = rec_cur;
    rec_new.last_change_time = change_time;
    rec_new.stable_level     = stable;
    rec_new.last_raw_level   = s1_raw;
    action                   = ACT_NONE;
    unique case (rec_cur.press_state)
      ST_IDLE: begin
        if (stable) begin
          rec_new.press_state      = ST_PRESSED;
          rec_new.press_start_time = s1_now;
        end
      end
      ST_PRESSED: begin
        if (stable) begin
          if (!is_relay && since_press >= {16'd0, long_press_ms}) begin
            rec_new.press_state = ST_HELD;
            if (s1_on) begin
              action = ACT_START_DIM;
            end
          end
        end else begin
          rec_new.press_state = ST_IDLE;
          action = is_relay ? ACT_TOGGLE_RELAY : ACT_TOGGLE_STRIP;
        end
      end
      ST_HELD: begin
        if (!stable) begin
          rec_new.press_state = ST_IDLE;
          if (!is_relay) begin
            action = ACT_STOP_DIM;
          end
        end
      end
      default: ;
    endcase
  end

  assign wr_en   = s1_advance && in_range;
  assign wr_addr = s1_addr;

  always_comb begin
    active_next          = active;
    active_next[s1_addr] = (rec_new.press_state == ST_PRESSED) ||
                           (rec_new.press_state == ST_HELD);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s1_advance) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      if (in_range) begin
        result.action       <= action;
        result.target_strip <= strip;
        result.button_state <= rec_new.press_state;
        result.any_active   <= |active_next;
      end else begin
        result.action       <= ACT_NONE;
        result.target_strip <= 8'd0;
        result.button_state <= ST_IDLE;
        result.any_active   <= |active;
      end
    end
  end

endmodule

// ===== verif/mbd_checker.sv =====
// result checker for the multi-button debounce block: tracks button state and compares beats
module mbd_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  mbd_sample_if       sample,
  mbd_result_if       result,
  output int          fail_count,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import mbd_pkg::*;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] target_strip;
    logic [1:0] button_state;
    logic       any_active;
  } result_beat_t;

  // shadow copy of the registers
  logic [15:0] debounce_ms;
  logic [15:0] hold_ms;
  logic [63:0] strip_map;

  // shadow copy of the per-button records
  logic [1:0]  btn_state     [BUTTON_COUNT];
  logic [31:0] btn_press_t   [BUTTON_COUNT];
  logic        btn_raw       [BUTTON_COUNT];
  logic [31:0] btn_change_t  [BUTTON_COUNT];
  logic        btn_stable    [BUTTON_COUNT];

  result_beat_t expected_results [$];

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic logic any_button_busy();
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      if (btn_state[i] == ST_PRESSED || btn_state[i] == ST_HELD) return 1'b1;
    end
    return 1'b0;
  endfunction

  // debounce then press / hold state machine for one sample
  function automatic result_beat_t predict_button_sample(logic [7:0] idx, logic lvl,
                                                         logic [31:0] now, logic strip_on);
    result_beat_t r;
    logic [7:0]   strip;
    logic         relay;
    logic [31:0]  since;
    int           b;
    r = '0;
    r.action = ACT_NONE;
    r.button_state = ST_IDLE;
    // out of range: nothing moves
    if (idx >= BUTTON_COUNT) begin
      r.any_active = any_button_busy();
      return r;
    end
    b = int'(idx);
    strip = strip_map[8*b +: 8];
    relay = (strip == RELAY_MARK);

    if (lvl != btn_raw[b]) btn_change_t[b] = now;
    since = now - btn_change_t[b];
    if (since > {16'd0, debounce_ms}) btn_stable[b] = lvl;
    btn_raw[b] = lvl;

    case (btn_state[b])
      ST_IDLE: begin
        if (btn_stable[b]) begin
          btn_state[b] = ST_PRESSED;
          btn_press_t[b] = now;
        end
      end
      ST_PRESSED: begin
        if (btn_stable[b]) begin
          since = now - btn_press_t[b];
          // relay buttons never reach the held state
          if (!relay && since >= {16'd0, hold_ms}) begin
            btn_state[b] = ST_HELD;
            if (strip_on) r.action = ACT_START_DIM;
          end
        end else begin
          btn_state[b] = ST_IDLE;
          r.action = relay ? ACT_TOGGLE_RELAY : ACT_TOGGLE_STRIP;
        end
      end
      ST_HELD: begin
        // a held button remapped to the relay goes quietly back to idle
        if (!btn_stable[b]) begin
          btn_state[b] = ST_IDLE;
          if (!relay) r.action = ACT_STOP_DIM;
        end
      end
      default: ;
    endcase

    r.target_strip = strip;
    r.button_state = btn_state[b];
    r.any_active = any_button_busy();
    return r;
  endfunction

  // watch both channels and the register port at each rising edge
  always @(posedge clk) begin
    result_beat_t got;
    result_beat_t want;
    if (rst) begin
      debounce_ms = DEBOUNCE_RESET;
      hold_ms = HOLD_RESET;
      strip_map = MAP_RESET;
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        btn_state[i] = ST_IDLE;
        btn_press_t[i] = '0;
        btn_raw[i] = 1'b0;
        btn_change_t[i] = '0;
        btn_stable[i] = 1'b0;
      end
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DEBOUNCE: debounce_ms = cfg_data[15:0];
          REG_HOLD:     hold_ms = cfg_data[15:0];
          REG_MAP:      strip_map = cfg_data;
          default: ;
        endcase
      end
      if (sample.valid && sample.ready) begin
        expected_results.push_back(predict_button_sample(sample.button_index,
                                                         sample.pressed_level,
                                                         sample.time_ms, sample.strip_on));
      end
      if (result.valid && result.ready) begin
        got = '{action: result.action, target_strip: result.target_strip,
                button_state: result.button_state, any_active: result.any_active};
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing pending (action %0d)",
                                    got.action));
        end else begin
          want = expected_results.pop_front();
          if (got.action !== want.action)
            report_mismatch($sformatf("action got %0d expected %0d",
                                      got.action, want.action));
          if (got.target_strip !== want.target_strip)
            report_mismatch($sformatf("target_strip got %0d expected %0d",
                                      got.target_strip, want.target_strip));
          if (got.button_state !== want.button_state)
            report_mismatch($sformatf("button_state got %0d expected %0d",
                                      got.button_state, want.button_state));
          if (got.any_active !== want.any_active)
            report_mismatch($sformatf("any_active got %0d expected %0d",
                                      got.any_active, want.any_active));
        end
      end
    end
    outstanding = expected_results.size();
  end

endmodule

// ===== verif/testbench.sv =====
// top of the multi-button debounce testbench: clock, reset, stimulus and verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mbd_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  mbd_sample_if sample ();
  mbd_result_if result ();

  int fail_count;
  int outstanding;

  // idling percentages and receiver hold-off request
  int   send_idle_pct;
  int   recv_idle_pct;
  logic long_stall_req;

  // running timestamp and the level each button is heading for
  logic [31:0] now_ms;
  logic [15:0] cur_debounce;
  logic [15:0] cur_hold;
  logic        btn_goal [BUTTON_COUNT];

  multi_button_debounce_hold dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample),
    .result    (result)
  );

  mbd_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample      (sample),
    .result      (result),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // run limit
  initial begin
    #5_000_000;
    $display("[multi_button_debounce_hold] ERROR");
    $finish;
  end

  // result side: random back-pressure plus an occasional long hold-off
  initial begin
    int stall_left;
    stall_left = 0;
    result.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        stall_left = 80;
      end
      if (stall_left > 0) begin
        stall_left--;
        result.ready <= 1'b0;
      end else begin
        result.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // offer one sample beat, time advanced by dt, and wait for it to be taken
  task automatic push_sample(logic [7:0] idx, logic lvl, logic [31:0] dt, logic strip_on);
    now_ms = now_ms + dt;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      sample.valid <= 1'b0;
      @(negedge clk);
    end
    sample.valid <= 1'b1;
    sample.button_index <= idx;
    sample.pressed_level <= lvl;
    sample.time_ms <= now_ms;
    sample.strip_on <= strip_on;
    do @(posedge clk); while (!sample.ready);
    @(negedge clk);
  endtask

  // stop offering and wait for every pending result
  task automatic drain();
    sample.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_regs(logic [15:0] debounce, logic [15:0] hold, logic [63:0] map);
    cfg_we <= 1'b1;
    cfg_index <= REG_DEBOUNCE;
    cfg_data <= {48'd0, debounce};
    @(negedge clk);
    cfg_index <= REG_HOLD;
    cfg_data <= {48'd0, hold};
    @(negedge clk);
    cfg_index <= REG_MAP;
    cfg_data <= map;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_debounce = debounce;
    cur_hold = hold;
  endtask

  // about a quarter of the buttons land on the relay
  function automatic logic [63:0] random_map();
    logic [63:0] m;
    for (int i = 0; i < 8; i++) begin
      if ($urandom_range(0, 3) == 0) m[8*i +: 8] = RELAY_MARK;
      else m[8*i +: 8] = 8'($urandom_range(0, 255));
    end
    return m;
  endfunction

  // press / release episodes with bounce, time steps scaled to the current registers
  task automatic random_phase(int count, bit with_stall);
    int          scale;
    logic [7:0]  idx;
    logic        lvl;
    logic [31:0] dt;
    scale = (cur_debounce > cur_hold ? cur_debounce : cur_hold) / 6 + 3;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 19) == 0) idx = 8'($urandom_range(BUTTON_COUNT, 255));
      else idx = 8'($urandom_range(0, BUTTON_COUNT - 1));
      if (idx < BUTTON_COUNT) begin
        if ($urandom_range(0, 5) == 0) begin
          btn_goal[idx[IDX_W-1:0]] = ~btn_goal[idx[IDX_W-1:0]];
        end
        lvl = ($urandom_range(0, 7) == 0) ? ~btn_goal[idx[IDX_W-1:0]]
                                          : btn_goal[idx[IDX_W-1:0]];
      end else begin
        lvl = 1'($urandom_range(0, 1));
      end
      if ($urandom_range(0, 49) == 0) dt = $urandom;
      else dt = $urandom_range(0, scale);
      if (with_stall && n == count / 2) long_stall_req = 1'b1;
      push_sample(idx, lvl, dt, 1'($urandom_range(0, 1)));
    end
    drain();
  endtask

  // stimulus
  initial begin
    logic [63:0] base_map;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_DEBOUNCE;
    cfg_data = '0;
    sample.valid = 1'b0;
    sample.button_index = '0;
    sample.pressed_level = 1'b0;
    sample.time_ms = '0;
    sample.strip_on = 1'b0;
    send_idle_pct = 22;
    recv_idle_pct = 46;
    long_stall_req = 1'b0;
    now_ms = 32'hFFFF_FFC0;
    for (int i = 0; i < BUTTON_COUNT; i++) btn_goal[i] = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: strips 0, 3, 254 and 5 on buttons 0..3, relay on button 7
    base_map = {RELAY_MARK, 8'd6, 8'd5, 8'd4, 8'd5, 8'd254, 8'd3, 8'd0};
    set_regs(16'd50, 16'd500, base_map);
    // short press on a strip button, edges of the debounce window, across the time wrap
    push_sample(8'd0, 1'b1, 32'd0, 1'b1);
    push_sample(8'd0, 1'b1, 32'd50, 1'b1);
    push_sample(8'd0, 1'b1, 32'd1, 1'b1);
    push_sample(8'd0, 1'b0, 32'd10, 1'b1);
    push_sample(8'd0, 1'b0, 32'd51, 1'b1);
    // relay button held long still only toggles the relay
    push_sample(8'd7, 1'b1, 32'd0, 1'b0);
    push_sample(8'd7, 1'b1, 32'd51, 1'b0);
    push_sample(8'd7, 1'b1, 32'd1000, 1'b1);
    push_sample(8'd7, 1'b0, 32'd0, 1'b0);
    push_sample(8'd7, 1'b0, 32'd51, 1'b0);
    // hold with strip on: one short of the threshold, then at it
    push_sample(8'd1, 1'b1, 32'd0, 1'b1);
    push_sample(8'd1, 1'b1, 32'd51, 1'b1);
    push_sample(8'd1, 1'b1, 32'd499, 1'b1);
    push_sample(8'd1, 1'b1, 32'd1, 1'b1);
    // out of range indexes while a button is held
    push_sample(8'd255, 1'b1, 32'd0, 1'b1);
    push_sample(8'd8, 1'b0, 32'd0, 1'b0);
    push_sample(8'd1, 1'b0, 32'd0, 1'b1);
    push_sample(8'd1, 1'b0, 32'd51, 1'b1);
    // hold with strip off, release still stops dimming
    push_sample(8'd2, 1'b1, 32'd0, 1'b0);
    push_sample(8'd2, 1'b1, 32'd51, 1'b0);
    push_sample(8'd2, 1'b1, 32'd500, 1'b0);
    push_sample(8'd2, 1'b0, 32'd0, 1'b0);
    push_sample(8'd2, 1'b0, 32'd51, 1'b0);
    // held button remapped to the relay before release
    push_sample(8'd3, 1'b1, 32'd0, 1'b1);
    push_sample(8'd3, 1'b1, 32'd51, 1'b1);
    push_sample(8'd3, 1'b1, 32'd500, 1'b0);
    drain();
    base_map[31:24] = RELAY_MARK;
    set_regs(16'd50, 16'd500, base_map);
    push_sample(8'd3, 1'b0, 32'd0, 1'b1);
    push_sample(8'd3, 1'b0, 32'd51, 1'b1);
    drain();

    // random phases: sender idles less than receiver
    set_regs(16'd50, 16'd500, random_map());
    random_phase(300, 1'b0);
    set_regs(16'd0, 16'd0, random_map());
    random_phase(300, 1'b1);

    // receiver idles less than sender
    send_idle_pct = 46;
    recv_idle_pct = 22;
    set_regs(16'hFFFF, 16'hFFFF, random_map());
    random_phase(300, 1'b0);
    set_regs(16'($urandom_range(0, 200)), 16'($urandom_range(0, 2000)), 64'd0);
    random_phase(300, 1'b0);

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_regs(16'hFFFF, 16'd0, random_map());
    random_phase(300, 1'b0);
    set_regs(16'd0, 16'hFFFF, random_map());
    random_phase(300, 1'b0);

    repeat (6) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[multi_button_debounce_hold] OK");
    end else begin
      $display("[multi_button_debounce_hold] ERROR");
    end
    $finish;
  end

endmodule

// ===== multi_button_debounce_hold.f =====
hw/rtl/mbd_pkg.sv
hw/rtl/mbd_if.sv
hw/rtl/multi_button_debounce_hold.sv
verif/mbd_checker.sv
verif/testbench.sv
